// ===== rtl/sha1md_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 digest block: controller states,
// pad byte sources, command and status groups, round and initial constants.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	localparam int unsigned WORDS      = 5;
	localparam int unsigned ROUNDS     = 80;
	localparam int unsigned SCHED      = 16;

	localparam logic [5:0]  POS_LAST   = 6'd63;
	localparam logic [5:0]  POS_LEN    = 6'd56;
	localparam logic [6:0]  RND_LAST   = 7'd79;
	localparam logic [6:0]  RND_PH1    = 7'd20;
	localparam logic [6:0]  RND_PH2    = 7'd40;
	localparam logic [6:0]  RND_PH3    = 7'd60;
	localparam logic [2:0]  IDX_LAST   = 3'd4;

	localparam logic [7:0]  PAD_BYTE   = 8'h80;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      push;        // shift one byte into the block
		byte_src_t src;         // where that byte comes from
		logic      count_inc;   // message byte taken
		logic      start;       // load working vars, clear round counter
		logic      round;       // run one compression round
		logic      fold;        // add working vars into chain
		logic      out_next;    // digest word taken
		logic      digest_done; // back to initial chain, clear count
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       round_last;
		logic       out_last;
	} sts_t;

endpackage

// ===== rtl/sha1md_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Controller: sequences byte loading, padding, compression and digest
// readout, and drives the request handshakes.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              final_byte,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sha1md_pkg::sts_t  sts,
	output sha1md_pkg::cmd_t  cmd
);
	import sha1md_pkg::*;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	state_t after_in;

	// hold state and return point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		cmd       = '0;
		cmd.src   = SRC_IN;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		after_in  = final_byte ? ST_PAD80 : ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.push      = 1'b1;
					cmd.src       = SRC_IN;
					cmd.count_inc = 1'b1;
					if (sts.pos == POS_LAST) begin
						cmd.start = 1'b1;
						ret_d     = after_in;
						state_d   = ST_COMP;
					end else begin
						state_d = after_in;
					end
				end
			end
			ST_PAD80: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_PAD;
				if (sts.pos == POS_LAST) begin
					cmd.start = 1'b1;
					ret_d     = ST_PADZ;
					state_d   = ST_COMP;
				end else begin
					state_d = ST_PADZ;
				end
			end
			ST_PADZ: begin
				if (sts.pos == POS_LEN) begin
					state_d = ST_PADLEN;
				end else begin
					cmd.push = 1'b1;
					cmd.src  = SRC_ZERO;
					if (sts.pos == POS_LAST) begin
						cmd.start = 1'b1;
						ret_d     = ST_PADZ;
						state_d   = ST_COMP;
					end
				end
			end
			ST_PADLEN: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN;
				if (sts.pos == POS_LAST) begin
					cmd.start = 1'b1;
					ret_d     = ST_OUT;
					state_d   = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				if (sts.round_last) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_next = 1'b1;
					if (sts.out_last) begin
						cmd.digest_done = 1'b1;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sha1md_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_datapath
// Datapath: block shift register that doubles as the message schedule,
// one SHA-1 round per cycle, chaining words, byte counters, digest readout.
// ----------------------------------------------------------------------------
module sha1md_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1md_pkg::cmd_t  cmd,
	output sha1md_pkg::sts_t  sts,
	input  logic [7:0]        data_byte,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import sha1md_pkg::*;

	logic [31:0] w_q [SCHED];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] chain_q [WORDS];
	logic [60:0] count_q;
	logic [5:0]  pos_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;

	logic [7:0]  byte_in;
	logic [63:0] len_shift;
	logic [31:0] f, k, w_new, tmp;

	// pick the byte to shift in
	assign len_shift = {count_q, 3'b000} << {pos_q[2:0], 3'b000};
	always_comb begin
		unique case (cmd.src)
			SRC_IN:   byte_in = data_byte;
			SRC_PAD:  byte_in = PAD_BYTE;
			SRC_ZERO: byte_in = 8'h00;
			SRC_LEN:  byte_in = len_shift[63:56];
			default:  byte_in = 8'h00;
		endcase
	end

	// round function and constant by phase
	always_comb begin
		if (rnd_q < RND_PH1) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < RND_PH2) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < RND_PH3) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	assign tmp   = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	assign w_new = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1
		| {31'd0, w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	// shift bytes in, or advance the schedule one word per round
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < SCHED - 1; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[SCHED - 1] <= {w_q[SCHED - 1][23:0], byte_in};
		end else if (cmd.round) begin
			for (int i = 0; i < SCHED - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[SCHED - 1] <= w_new;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// chaining words: fold after each block, reload after a digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else if (cmd.digest_done) begin
			for (int i = 0; i < WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else if (cmd.fold) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
		end else begin
			if (cmd.digest_done) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + 61'd1;
			end
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (cmd.digest_done) begin
				oidx_q <= '0;
			end else if (cmd.out_next) begin
				oidx_q <= oidx_q + 3'd1;
			end
		end
	end

	assign sts.pos        = pos_q;
	assign sts.round_last = (rnd_q == RND_LAST);
	assign sts.out_last   = (oidx_q == IDX_LAST);

	assign digest_word = chain_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == IDX_LAST);

endmodule

// ===== rtl/sha1_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream: one byte per request, five digest words out.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while no compression is running;
// every 64th byte (message or padding) starts a compression that holds off
// input for 80 rounds at one round per cycle in the shared round unit and
// then for a fold of the result into the chaining words. After the byte
// flagged final the block pads one byte a cycle outside compressions, with
// an idle step in ST_PADZ before the length bytes (up to 64 bytes, or up
// to 72 when the length spills into an extra block), runs the last
// compression, then offers the digest as five words, word 0 first, word 4
// marked last, one per output request. It then starts a new message from
// the initial chaining values. Input is not taken while padding,
// compressing or reading out.
// ----------------------------------------------------------------------------
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1md_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the work
	sha1md_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.final_byte (final_byte),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// hash the bytes
	sha1md_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (data_byte),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
